[hw/rtl/ctlc_pkg.sv]
`timescale 1ns / 1ps
package ctlc_pkg;
   localparam int MAX_TRACKS = 16;
   localparam int IDX_W = $clog2(MAX_TRACKS);
   localparam int CNT_W = $clog2(MAX_TRACKS + 1);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] ST_REJECT = 3'd0;
   localparam logic [2:0] ST_MATCH = 3'd1;
   localparam logic [2:0] ST_NEW = 3'd2;
   localparam logic [2:0] ST_FULL = 3'd3;
   localparam logic [2:0] ST_TICK = 3'd4;

   localparam logic [2:0] REG_MIN_AREA = 3'd0;
   localparam logic [2:0] REG_BAND_TOP = 3'd1;
   localparam logic [2:0] REG_BAND_BOTTOM = 3'd2;
   localparam logic [2:0] REG_LINE_UP = 3'd3;
   localparam logic [2:0] REG_LINE_DOWN = 3'd4;
   localparam logic [2:0] REG_MAX_AGE = 3'd5;

   typedef struct packed {
      logic       mode;
      logic [9:0] x_center;
      logic [9:0] y_center;
      logic [9:0] box_width;
      logic [9:0] box_height;
      logic [19:0] blob_area;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] track_number;
      logic        crossed_up;
      logic        crossed_down;
      logic [15:0] up_total;
      logic [15:0] down_total;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      logic       tick;
      logic       reject;
      logic [9:0] x;
      logic [9:0] y;
      logic [9:0] bw;
      logic [9:0] bh;
   } cmd_type;

   typedef struct packed {
      logic [19:0] min_area;
      logic [9:0]  band_top;
      logic [9:0]  band_bottom;
      logic [9:0]  line_up;
      logic [9:0]  line_down;
      logic [4:0]  max_age;
   } cfg_type;

   typedef struct packed {
      logic [9:0]  x;
      logic [9:0]  y;
      logic [9:0]  py;
      logic [9:0]  p2y;
      logic [1:0]  hlen;
      logic [2:0]  flags;
      logic [4:0]  age;
      logic [15:0] id;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE, S_TICK, S_WALK, S_SHIFT, S_DONE
   } state_type;
endpackage

[hw/rtl/ctlc_front.sv]
`timescale 1ns / 1ps
module ctlc_front import ctlc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   input  cfg_type cfg,
   output logic    cmd_valid,
   output cmd_type cmd_data,
   input  logic    cmd_pop,
   input  logic    back_idle
);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   cmd_type q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [PTR_W:0] cnt_ff, cnt_in;
   logic push;
   cmd_type c;

   // one item in flight at a time through the queue and back end
   assign busy = (cnt_ff != '0) || !back_idle;
   assign push = start && !busy;

   // classify: tick, reject, or table walk
   always_comb begin
      c.tick = !req_data.mode;
      c.reject = req_data.mode && !(req_data.blob_area > cfg.min_area &&
         req_data.y_center > cfg.band_top && req_data.y_center < cfg.band_bottom);
      c.x = req_data.x_center;
      c.y = req_data.y_center;
      c.bw = req_data.box_width;
      c.bh = req_data.box_height;
   end

   always_comb begin
      wp_in = push ? wp_ff + 1'b1 : wp_ff;
      rp_in = cmd_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wp_ff] <= c;
   end

   assign cmd_valid = cnt_ff != '0;
   assign cmd_data = q_ff[rp_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PTR_W+1)'(QUEUE_DEPTH)) else $error("queue overflow");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid) else $error("pop from empty queue");
   a_push_busy: assert property (@(posedge clock) disable iff (reset)
      push |=> busy) else $error("busy not raised");
endmodule

[hw/rtl/ctlc_back.sv]
`timescale 1ns / 1ps
module ctlc_back import ctlc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd_data,
   output logic    cmd_pop,
   output logic    back_idle,
   input  cfg_type cfg,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   entry_type tab_ff [MAX_TRACKS];
   entry_type tab_in [MAX_TRACKS];
   logic [CNT_W-1:0] count_ff, count_in, pos_ff, pos_in, sh_ff, sh_in;
   logic [15:0] next_id_ff, next_id_in, up_ff, up_in, down_ff, down_in;
   state_type state_ff, state_in;
   cmd_type cmd_ff, cmd_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_v_ff, rsp_v_in;
   entry_type cur, upd;
   logic [9:0] dx, dy;
   logic hit, fin, cu, cd;
   logic [5:0] age_inc;

   // current entry under the walk pointer
   always_comb begin
      cur = tab_ff[pos_ff[IDX_W-1:0]];
      dx = (cmd_ff.x > cur.x) ? cmd_ff.x - cur.x : cur.x - cmd_ff.x;
      dy = (cmd_ff.y > cur.y) ? cmd_ff.y - cur.y : cur.y - cmd_ff.y;
      hit = dx <= cmd_ff.bw && dy <= cmd_ff.bh;
      fin = cur.flags[0] || (cur.flags[1] &&
         ((cur.flags[2] && cur.y > cfg.band_bottom) ||
          (!cur.flags[2] && cur.y < cfg.band_top)));
      age_inc = {1'b0, cur.age} + 6'd1;
      // matched entry update with crossing test
      upd = cur;
      upd.p2y = cur.py;
      upd.py = cur.y;
      upd.x = cmd_ff.x;
      upd.y = cmd_ff.y;
      upd.age = '0;
      upd.hlen = (cur.hlen < 2'd2) ? cur.hlen + 2'd1 : cur.hlen;
      cu = 1'b0;
      cd = 1'b0;
      if (upd.hlen >= 2'd2 && !cur.flags[1]) begin
         if (upd.py < cfg.line_up && upd.p2y > cfg.line_up) begin
            cu = 1'b1;
            upd.flags = {1'b0, 1'b1, cur.flags[0]};
         end else if (upd.py > cfg.line_down && upd.p2y < cfg.line_down) begin
            cd = 1'b1;
            upd.flags = {1'b1, 1'b1, cur.flags[0]};
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (cmd_valid) begin
            if (cmd_data.tick) state_in = S_TICK;
            else if (cmd_data.reject) state_in = S_DONE;
            else state_in = S_WALK;
         end
         S_TICK: if (pos_ff + 1'b1 >= count_ff) state_in = S_DONE;
         S_WALK: if (pos_ff >= count_ff || hit) state_in = S_DONE;
            else if (fin) begin
               // removing the last entry needs no shift
               if (pos_ff + 1'b1 < count_ff) state_in = S_SHIFT;
            end
         S_SHIFT: if (sh_ff + 2'd2 >= count_ff) state_in = S_WALK;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      tab_in = tab_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      sh_in = sh_ff;
      next_id_in = next_id_ff;
      up_in = up_ff;
      down_in = down_ff;
      cmd_in = cmd_ff;
      rsp_in = rsp_ff;
      rsp_v_in = 1'b0;
      cmd_pop = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            pos_in = '0;
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in = cmd_data;
               rsp_in = '{ST_REJECT, 16'd0, 1'b0, 1'b0, up_ff, down_ff};
               if (cmd_data.tick) rsp_in.status = ST_TICK;
            end
         end
         S_TICK: begin
            if (pos_ff < count_ff) begin
               if (age_inc > {1'b0, cfg.max_age})
                  tab_in[pos_ff[IDX_W-1:0]].flags[0] = 1'b1;
               tab_in[pos_ff[IDX_W-1:0]].age = age_inc[5] ? 5'd31 : age_inc[4:0];
            end
            pos_in = pos_ff + 1'b1;
         end
         S_WALK: begin
            if (pos_ff >= count_ff) begin
               if (count_ff >= CNT_W'(MAX_TRACKS)) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  tab_in[count_ff[IDX_W-1:0]] = '{cmd_ff.x, cmd_ff.y, 10'd0, 10'd0,
                     2'd0, 3'd0, 5'd0, next_id_ff};
                  count_in = count_ff + 1'b1;
                  next_id_in = next_id_ff + 16'd1;
                  rsp_in.status = ST_NEW;
                  rsp_in.track_number = next_id_ff;
               end
            end else if (hit) begin
               tab_in[pos_ff[IDX_W-1:0]] = upd;
               up_in = up_ff + 16'(cu);
               down_in = down_ff + 16'(cd);
               rsp_in = '{ST_MATCH, cur.id, cu, cd, up_ff + 16'(cu), down_ff + 16'(cd)};
            end else if (fin) begin
               sh_in = pos_ff;
               if (pos_ff + 1'b1 >= count_ff) count_in = count_ff - 1'b1;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         S_SHIFT: begin
            // move one entry down per cycle, then drop the last
            if (sh_ff + 1'b1 < count_ff)
               tab_in[sh_ff[IDX_W-1:0]] = tab_ff[sh_ff[IDX_W-1:0] + 1'b1];
            sh_in = sh_ff + 1'b1;
            if (sh_ff + 2'd2 >= count_ff) count_in = count_ff - 1'b1;
         end
         S_DONE: rsp_v_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         next_id_ff <= 16'd1;
         up_ff <= '0;
         down_ff <= '0;
         rsp_v_ff <= 1'b0;
         pos_ff <= '0;
         sh_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         next_id_ff <= next_id_in;
         up_ff <= up_in;
         down_ff <= down_in;
         rsp_v_ff <= rsp_v_in;
         pos_ff <= pos_in;
         sh_ff <= sh_in;
      end
      tab_ff <= tab_in;
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   assign back_idle = state_ff == S_IDLE && !rsp_v_ff;
   assign rsp_valid = rsp_v_ff;
   assign rsp_data = rsp_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TRACKS)) else $error("table count overflow");
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> rsp_valid) else $error("missing result");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double result");
endmodule

[hw/rtl/ctlc_csr.sv]
`timescale 1ns / 1ps
module ctlc_csr import ctlc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_data,
   output cfg_type     cfg
);
   cfg_type cfg_ff, cfg_in;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_MIN_AREA: cfg_in.min_area = csr_data;
            REG_BAND_TOP: cfg_in.band_top = csr_data[9:0];
            REG_BAND_BOTTOM: cfg_in.band_bottom = csr_data[9:0];
            REG_LINE_UP: cfg_in.line_up = csr_data[9:0];
            REG_LINE_DOWN: cfg_in.line_down = csr_data[9:0];
            REG_MAX_AGE: cfg_in.max_age = csr_data[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= '{20'd1228, 10'd48, 10'd432, 10'd96, 10'd384, 5'd5};
      else cfg_ff <= cfg_in;
   end

   assign cfg = cfg_ff;
endmodule

[hw/rtl/centroid_tracker_line_counter.sv]
`timescale 1ns / 1ps
// channel | ports                              | handshake
// input   | start, busy, req_data              | taken when start && !busy
// result  | rsp_valid, rsp_data                | one-cycle strobe, no stall
// config  | csr_write, csr_index, csr_data     | written when csr_write
// From accept, a command waits in the queue until the back end pops it in S_IDLE; a
// reject goes straight to S_DONE, a tick ages every entry in S_TICK, and a detection
// walks entries in S_WALK up to the match or insert, with each removal moving the
// later entries down in S_SHIFT; S_DONE then raises the registered result strobe.
// Synchronous active-high reset empties the table; no clearing pass.
// The result strobe cannot be held off; busy stays high until it has gone out,
// so the next item is taken in the cycle after the strobe at the earliest.
module centroid_tracker_line_counter import ctlc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_data
);
   cfg_type cfg;
   logic cmd_valid, cmd_pop, back_idle;
   cmd_type cmd_data;

   ctlc_csr u_csr (.clock, .reset, .csr_write, .csr_index, .csr_data, .cfg);
   ctlc_front u_front (.clock, .reset, .start, .busy, .req_data, .cfg,
      .cmd_valid, .cmd_data, .cmd_pop, .back_idle);
   ctlc_back u_back (.clock, .reset, .cmd_valid, .cmd_data, .cmd_pop, .back_idle,
      .cfg, .rsp_valid, .rsp_data);
endmodule
